// File: hw/rtl/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: Q16 types, range limits, the
// percent-to-Q16 lookup table and the reciprocal used for the hue fraction.
// Depends on nothing; every converter file refers to it by scoped names.
`default_nettype none

package hsvrgb_pkg;

   localparam int Q16_WIDTH = 17;

   typedef logic [Q16_WIDTH-1:0] q16_type;
   typedef logic [7:0]           channel_type;
   typedef logic [2:0]           sector_type;
   typedef logic [9:0]           hue_offset_type;

   localparam int HUE_LIMIT    = 5760;
   localparam int PCT_LIMIT    = 100;
   localparam int SECTOR_UNITS = 960;
   localparam int SECTOR_COUNT = 6;
   localparam int ONE_Q16      = 65536;
   localparam int FULL_SCALE   = 255;

   // The hue fraction is offset * 1024 / 15. The reciprocal of 15 at 24 bits
   // gives a quotient that is at most one short, which a single compare fixes.
   localparam int              RECIP_BITS  = 21;
   localparam logic [20:0]     RECIP_15    = 21'((2 ** 24) / 15);
   localparam int              RECIP_SHIFT = 14;
   localparam int              DIVISOR     = 15;

   typedef q16_type pct_table_type [128];

   function automatic pct_table_type build_pct_table();
      pct_table_type table_q;
      for (int i = 0; i < 128; i++) begin
         table_q[i] = q16_type'((i * ONE_Q16) / PCT_LIMIT);
      end
      return table_q;
   endfunction

   localparam pct_table_type PCT_TO_Q16 = build_pct_table();

endpackage

`default_nettype wire

// File: hw/rtl/hsvrgb_scale.sv
// Channel scaler: turns a Q16 level into an 8-bit code, floor(level*255/65536).
// Depends on hsvrgb_pkg for the Q16 and channel types.
`default_nettype none

module hsvrgb_scale (
   input  hsvrgb_pkg::q16_type     level,
   output hsvrgb_pkg::channel_type code
);

   logic [24:0] product;

   // A level of at most 1.0 keeps the product below 2^24.
   assign product = 25'(level) * 25'(hsvrgb_pkg::FULL_SCALE);
   assign code    = product[23:16];

endmodule

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: five-stage pipeline with valid bits.
// Depends on hsvrgb_pkg and hsvrgb_scale.
//
// Usage:
// The request channel (req_valid, req_ready) carries hue in 1/16 degree and
// saturation and brightness in whole percent. The response channel
// (rsp_valid, rsp_ready) carries 8-bit red, green and blue and an
// out-of-range flag; an out-of-range transaction returns black.
// Every transaction passes five register stages: table lookup and sector
// split, chroma and reciprocal multiply, fraction correction, second
// component multiply, then channel selection and scaling into the output
// register. After the accepting edge the result moves through the registers
// of stages two to five and is presented from the output register. One
// transaction is accepted in every cycle while the receiver takes results;
// the two 17 by 17 bit multipliers sit each in a stage of its own.
// Each stage moves on when it is empty or when the stage after it moves, so
// bubbles close up. When the receiver stalls, results hold in place and
// req_ready falls only once all five stages are full.
// Reset is synchronous and clears every valid bit, so transactions in flight are dropped.
`default_nettype none

module hsv_to_rgb_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [12:0] req_hue,
   input  wire logic [6:0]  req_saturation,
   input  wire logic [6:0]  req_brightness,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic             rsp_out_of_range
);

   logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                          rsp_valid_ff;

   logic                          s1_oor_ff, s1_oor_in;
   hsvrgb_pkg::q16_type           s1_s_ff, s1_s_in;
   hsvrgb_pkg::q16_type           s1_v_ff, s1_v_in;
   hsvrgb_pkg::hue_offset_type    s1_k_ff, s1_k_in;
   hsvrgb_pkg::sector_type        s1_sector_ff, s1_sector_in;

   logic                          s2_oor_ff;
   hsvrgb_pkg::q16_type           s2_c_ff, s2_c_in;
   hsvrgb_pkg::q16_type           s2_v_ff;
   logic [30:0]                   s2_kprod_ff, s2_kprod_in;
   hsvrgb_pkg::hue_offset_type    s2_k_ff;
   hsvrgb_pkg::sector_type        s2_sector_ff;

   logic                          s3_oor_ff;
   hsvrgb_pkg::q16_type           s3_c_ff;
   hsvrgb_pkg::q16_type           s3_m_ff, s3_m_in;
   hsvrgb_pkg::q16_type           s3_f_ff, s3_f_in;
   hsvrgb_pkg::sector_type        s3_sector_ff;

   logic                          s4_oor_ff;
   hsvrgb_pkg::q16_type           s4_c_ff;
   hsvrgb_pkg::q16_type           s4_m_ff;
   hsvrgb_pkg::q16_type           s4_x_ff, s4_x_in;
   hsvrgb_pkg::sector_type        s4_sector_ff;

   hsvrgb_pkg::channel_type       rsp_red_ff, rsp_red_in;
   hsvrgb_pkg::channel_type       rsp_green_ff, rsp_green_in;
   hsvrgb_pkg::channel_type       rsp_blue_ff, rsp_blue_in;
   logic                          rsp_oor_ff;

   logic [12:0]                   hue_base;
   logic [12:0]                   hue_rem;
   logic [33:0]                   sv_product;
   logic [33:0]                   cf_product;
   hsvrgb_pkg::q16_type           quot_est;
   logic [20:0]                   quot_times15;
   logic [20:0]                   quot_resid;
   hsvrgb_pkg::q16_type           red_level, green_level, blue_level;
   hsvrgb_pkg::q16_type           sel_r, sel_g, sel_b;
   hsvrgb_pkg::channel_type       red_code, green_code, blue_code;

   assign adv_s5    = !rsp_valid_ff || rsp_ready;
   assign adv_s4    = !s4_valid_ff || adv_s5;
   assign adv_s3    = !s3_valid_ff || adv_s4;
   assign adv_s2    = !s2_valid_ff || adv_s3;
   assign adv_s1    = !s1_valid_ff || adv_s2;
   assign req_ready = adv_s1;

   // Stage one: range check, percent lookups and the sixty-degree split.
   always_comb begin
      s1_oor_in = (req_hue > 13'(hsvrgb_pkg::HUE_LIMIT))
               || (req_saturation > 7'(hsvrgb_pkg::PCT_LIMIT))
               || (req_brightness > 7'(hsvrgb_pkg::PCT_LIMIT));
      s1_s_in = hsvrgb_pkg::PCT_TO_Q16[req_saturation];
      s1_v_in = hsvrgb_pkg::PCT_TO_Q16[req_brightness];
      s1_sector_in = '0;
      for (int i = 1; i <= hsvrgb_pkg::SECTOR_COUNT; i++) begin
         s1_sector_in = s1_sector_in
                      + 3'(req_hue >= 13'(i * hsvrgb_pkg::SECTOR_UNITS));
      end
      hue_base = 13'(s1_sector_in) * 13'(hsvrgb_pkg::SECTOR_UNITS);
      hue_rem  = req_hue - hue_base;
      if (s1_sector_in[0]) begin
         s1_k_in = 10'(13'(hsvrgb_pkg::SECTOR_UNITS) - hue_rem);
      end else begin
         s1_k_in = hue_rem[9:0];
      end
   end

   // Stage two: chroma and the reciprocal product for the hue fraction.
   always_comb begin
      sv_product  = 34'(s1_s_ff) * 34'(s1_v_ff);
      s2_c_in     = sv_product[32:16];
      s2_kprod_in = 31'(s1_k_ff) * 31'(hsvrgb_pkg::RECIP_15);
   end

   // Stage three: quotient correction and the offset m = v - c.
   always_comb begin
      quot_est     = s2_kprod_ff[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::Q16_WIDTH];
      quot_times15 = 21'(quot_est) * 21'(hsvrgb_pkg::DIVISOR);
      quot_resid   = 21'({s2_k_ff, 10'b0}) - quot_times15;
      s3_f_in      = quot_est + hsvrgb_pkg::q16_type'(quot_resid >= 21'(hsvrgb_pkg::DIVISOR));
      s3_m_in      = s2_v_ff - s2_c_ff;
   end

   // Stage four: the second component x = c * f.
   always_comb begin
      cf_product = 34'(s3_c_ff) * 34'(s3_f_ff);
      s4_x_in    = cf_product[32:16];
   end

   // Stage five: sector selection and scaling, with black for an out-of-range transaction.
   always_comb begin
      case (s4_sector_ff)
         3'd0: begin
            sel_r = s4_c_ff; sel_g = s4_x_ff; sel_b = '0;
         end
         3'd1: begin
            sel_r = s4_x_ff; sel_g = s4_c_ff; sel_b = '0;
         end
         3'd2: begin
            sel_r = '0; sel_g = s4_c_ff; sel_b = s4_x_ff;
         end
         3'd3: begin
            sel_r = '0; sel_g = s4_x_ff; sel_b = s4_c_ff;
         end
         3'd4: begin
            sel_r = s4_x_ff; sel_g = '0; sel_b = s4_c_ff;
         end
         default: begin
            sel_r = s4_c_ff; sel_g = '0; sel_b = s4_x_ff;
         end
      endcase
      red_level   = sel_r + s4_m_ff;
      green_level = sel_g + s4_m_ff;
      blue_level  = sel_b + s4_m_ff;
      if (s4_oor_ff) begin
         rsp_red_in   = '0;
         rsp_green_in = '0;
         rsp_blue_in  = '0;
      end else begin
         rsp_red_in   = red_code;
         rsp_green_in = green_code;
         rsp_blue_in  = blue_code;
      end
   end

   hsvrgb_scale u_scale_red   (.level(red_level),   .code(red_code));
   hsvrgb_scale u_scale_green (.level(green_level), .code(green_code));
   hsvrgb_scale u_scale_blue  (.level(blue_level),  .code(blue_code));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv_s1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv_s2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv_s3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv_s4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (adv_s5) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         s1_oor_ff    <= s1_oor_in;
         s1_s_ff      <= s1_s_in;
         s1_v_ff      <= s1_v_in;
         s1_k_ff      <= s1_k_in;
         s1_sector_ff <= s1_sector_in;
      end
      if (adv_s2) begin
         s2_oor_ff    <= s1_oor_ff;
         s2_c_ff      <= s2_c_in;
         s2_v_ff      <= s1_v_ff;
         s2_kprod_ff  <= s2_kprod_in;
         s2_k_ff      <= s1_k_ff;
         s2_sector_ff <= s1_sector_ff;
      end
      if (adv_s3) begin
         s3_oor_ff    <= s2_oor_ff;
         s3_c_ff      <= s2_c_ff;
         s3_m_ff      <= s3_m_in;
         s3_f_ff      <= s3_f_in;
         s3_sector_ff <= s2_sector_ff;
      end
      if (adv_s4) begin
         s4_oor_ff    <= s3_oor_ff;
         s4_c_ff      <= s3_c_ff;
         s4_m_ff      <= s3_m_ff;
         s4_x_ff      <= s4_x_in;
         s4_sector_ff <= s3_sector_ff;
      end
      if (adv_s5) begin
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
         rsp_oor_ff   <= s4_oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red          = rsp_red_ff;
   assign rsp_green        = rsp_green_ff;
   assign rsp_blue         = rsp_blue_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // An out-of-range transaction always leaves as black.
   a_oor_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> (rsp_red == 8'd0) && (rsp_green == 8'd0)
                                        && (rsp_blue == 8'd0))
      else $error("out-of-range transaction did not return black");

   // With the output register empty, every stage can move, so a request is taken.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output register was empty");

   // Reset clears the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid directly after reset");

endmodule

`default_nettype wire
